### src/mexp_pkg.sv
// Package: shared widths, sequencer states and multiplier handshake types for modular_exponentiation.
`default_nettype none
package mexp_pkg;

    localparam int WORD_BITS = 32;
    localparam int CNT_BITS  = $clog2(WORD_BITS);

    typedef logic [WORD_BITS-1:0] t_word;

    // sequencer states of the top level
    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_RED_W,
        S_BIT,
        S_ACC_W,
        S_SQR,
        S_SQR_W,
        S_DONE
    } t_state;

    // request to the shared modular multiplier
    typedef struct packed {
        logic  start;
        t_word opa;
        t_word opb;
        t_word modulus;
    } t_mul_req;

    // response from the shared modular multiplier
    typedef struct packed {
        logic  busy;
        logic  done;
        t_word product;
    } t_mul_rsp;

endpackage
`default_nettype wire

### src/mexp_if.sv
// Interfaces: input and output word channels of modular_exponentiation.
`default_nettype none
interface mexp_in_if;
    logic                valid;
    logic                ready;
    mexp_pkg::t_word     base_value;
    mexp_pkg::t_word     exponent;
    mexp_pkg::t_word     modulus;

    modport source (output valid, output base_value, output exponent, output modulus,
                    input ready);
    modport sink   (input valid, input base_value, input exponent, input modulus,
                    output ready);
endinterface

interface mexp_out_if;
    logic                valid;
    logic                ready;
    mexp_pkg::t_word     power_result;
    logic                bad_modulus;

    modport source (output valid, output power_result, output bad_modulus, input ready);
    modport sink   (input valid, input power_result, input bad_modulus, output ready);
endinterface
`default_nettype wire

### src/mexp_mulmod.sv
// Module: shared shift-and-add modular multiplier, one multiplier bit per cycle.
`default_nettype none
module mexp_mulmod (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  mexp_pkg::t_mul_req  i_req,
    output mexp_pkg::t_mul_rsp  o_rsp
);

    localparam int W = mexp_pkg::WORD_BITS;

    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [mexp_pkg::CNT_BITS-1:0] r_cnt, n_cnt;
    mexp_pkg::t_word               r_acc, n_acc;
    mexp_pkg::t_word               r_a, n_a;
    mexp_pkg::t_word               r_b, n_b;
    mexp_pkg::t_word               r_m, n_m;

    logic [W:0] w_dbl;
    logic [W:0] w_dbl_red;
    logic [W:0] w_add;
    logic [W:0] w_sum;
    logic [W:0] w_sum_red;

    // double the accumulator, reduce, add the multiplicand on a set bit, reduce
    always_comb begin
        w_dbl     = {r_acc, 1'b0};
        w_dbl_red = (w_dbl >= {1'b0, r_m}) ? (w_dbl - {1'b0, r_m}) : w_dbl;
        w_add     = r_b[W-1] ? {1'b0, r_a} : '0;
        w_sum     = {1'b0, w_dbl_red[W-1:0]} + w_add;
        w_sum_red = (w_sum >= {1'b0, r_m}) ? (w_sum - {1'b0, r_m}) : w_sum;
    end

    // load on start, then advance one bit a cycle, most significant first
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        n_m    = r_m;
        if (i_req.start && !r_busy) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_acc  = '0;
            n_a    = i_req.opa;
            n_b    = i_req.opb;
            n_m    = i_req.modulus;
        end else if (r_busy) begin
            n_acc = w_sum_red[W-1:0];
            n_b   = {r_b[W-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == mexp_pkg::CNT_BITS'(W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // hold control under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // operand and accumulator registers
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
        r_m   <= n_m;
    end

    assign o_rsp.busy    = r_busy;
    assign o_rsp.done    = r_done;
    assign o_rsp.product = r_acc;

endmodule
`default_nettype wire

### src/modular_exponentiation.sv
// Top level: square-and-multiply sequencer around one shared modular multiplier.
// Usage:
//   i_req carries a word of base_value, exponent and modulus; o_rsp returns one word
//   of power_result and bad_modulus for each accepted input word.
//   i_req.ready is high only while the sequencer is idle; one word is worked at a time.
//   A zero exponent returns 1, a zero modulus with a nonzero exponent returns 0 with
//   bad_modulus set; both go straight to S_DONE and into the output register, and
//   the input reopens once the result is loaded there.
//   Otherwise the base is first reduced by one modular product, then each exponent bit,
//   least significant first, costs one squaring and, when set, one further product,
//   stopping once the remaining exponent bits are zero.
//   Each modular product runs on the shared multiplier, and the sequencer waits for its
//   done in a wait state; the result then passes through S_DONE into the output
//   register, and the input reopens once it is loaded there.
//   The result sits in an output register: it waits there while the receiver stalls,
//   and a new input word is taken meanwhile; the following result waits until the
//   register is emptied.
//   Reset (synchronous, active low) returns the sequencer to idle and empties the
//   output register; no state survives between words.
`default_nettype none
module modular_exponentiation (
    input  wire               i_clk,
    input  wire               i_rst_n,
    mexp_in_if.sink           i_req,
    mexp_out_if.source        o_rsp
);

    localparam int W = mexp_pkg::WORD_BITS;

    mexp_pkg::t_state   r_state, n_state;
    mexp_pkg::t_word    r_exp;
    mexp_pkg::t_word    r_base;
    mexp_pkg::t_word    r_m;
    mexp_pkg::t_word    r_acc;
    mexp_pkg::t_word    r_sq;
    logic               r_bad;
    logic               r_out_valid;
    mexp_pkg::t_word    r_out_result;
    logic               r_out_bad;

    mexp_pkg::t_mul_req w_mul_req;
    mexp_pkg::t_mul_rsp w_mul_rsp;
    logic               w_in_ready;
    logic               w_accept;
    logic               w_out_load;

    mexp_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_rsp   (w_mul_rsp)
    );

    assign w_accept = i_req.valid && w_in_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mexp_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (i_req.exponent == '0 || i_req.modulus == '0) begin
                        n_state = mexp_pkg::S_DONE;
                    end else begin
                        n_state = mexp_pkg::S_RED;
                    end
                end
            end
            mexp_pkg::S_RED:   n_state = mexp_pkg::S_RED_W;
            mexp_pkg::S_RED_W: begin
                if (w_mul_rsp.done) begin
                    n_state = mexp_pkg::S_BIT;
                end
            end
            mexp_pkg::S_BIT: begin
                if (r_exp == '0) begin
                    n_state = mexp_pkg::S_DONE;
                end else if (r_exp[0]) begin
                    n_state = mexp_pkg::S_ACC_W;
                end else begin
                    n_state = mexp_pkg::S_SQR_W;
                end
            end
            mexp_pkg::S_ACC_W: begin
                if (w_mul_rsp.done) begin
                    n_state = mexp_pkg::S_SQR;
                end
            end
            mexp_pkg::S_SQR:   n_state = mexp_pkg::S_SQR_W;
            mexp_pkg::S_SQR_W: begin
                if (w_mul_rsp.done) begin
                    n_state = mexp_pkg::S_BIT;
                end
            end
            mexp_pkg::S_DONE: begin
                if (w_out_load) begin
                    n_state = mexp_pkg::S_IDLE;
                end
            end
            default: n_state = mexp_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer: multiplier requests, input ready, output load
    always_comb begin
        w_mul_req.start   = 1'b0;
        w_mul_req.opa     = r_acc;
        w_mul_req.opb     = r_sq;
        w_mul_req.modulus = r_m;
        w_in_ready        = 1'b0;
        w_out_load        = 1'b0;
        case (r_state)
            mexp_pkg::S_IDLE: w_in_ready = 1'b1;
            mexp_pkg::S_RED: begin
                // reduce the base as (1 mod m) times base
                w_mul_req.start = 1'b1;
                w_mul_req.opb   = r_base;
            end
            mexp_pkg::S_BIT: begin
                if (r_exp != '0) begin
                    w_mul_req.start = 1'b1;
                    if (!r_exp[0]) begin
                        w_mul_req.opa = r_sq;
                    end
                end
            end
            mexp_pkg::S_SQR: begin
                w_mul_req.start = 1'b1;
                w_mul_req.opa   = r_sq;
            end
            mexp_pkg::S_DONE: w_out_load = !r_out_valid || o_rsp.ready;
            default: ;
        endcase
    end

    // hold control under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mexp_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers: capture the word, then take products as they finish
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_base <= i_req.base_value;
            r_exp  <= i_req.exponent;
            r_m    <= i_req.modulus;
            r_bad  <= (i_req.exponent != '0) && (i_req.modulus == '0);
            if (i_req.exponent == '0) begin
                r_acc <= W'(1);
            end else if (i_req.modulus == '0 || i_req.modulus == W'(1)) begin
                r_acc <= '0;
            end else begin
                r_acc <= W'(1);
            end
        end
        if (w_mul_rsp.done) begin
            case (r_state)
                mexp_pkg::S_ACC_W: r_acc <= w_mul_rsp.product;
                mexp_pkg::S_RED_W: r_sq  <= w_mul_rsp.product;
                mexp_pkg::S_SQR_W: begin
                    r_sq  <= w_mul_rsp.product;
                    r_exp <= {1'b0, r_exp[W-1:1]};
                end
                default: ;
            endcase
        end
        if (w_out_load) begin
            r_out_result <= r_acc;
            r_out_bad    <= r_bad;
        end
    end

    assign i_req.ready        = w_in_ready;
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.power_result = r_out_result;
    assign o_rsp.bad_modulus  = r_out_bad;

`ifndef SYNTHESIS
    // a flagged modulus always comes with a zero result
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.bad_modulus) |-> (o_rsp.power_result == '0))
        else $error("bad_modulus set with nonzero power_result");

    // the shared multiplier is never started while it is still working
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_req.start |-> !w_mul_rsp.busy)
        else $error("multiplier started while busy");

    // a finished product is only ever awaited in a wait state
    a_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_rsp.done |-> (r_state == mexp_pkg::S_RED_W || r_state == mexp_pkg::S_ACC_W
                            || r_state == mexp_pkg::S_SQR_W))
        else $error("product finished outside a wait state");

    // an accepted word closes the input straight after it is taken
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("input taken while a word is in work");
`endif

endmodule
`default_nettype wire

### tb/sv/mexp_checker.sv
// Checker: watches both word channels, predicts each power and compares it on return.
module mexp_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    mexp_in_if     i_req,
    mexp_out_if    i_rsp,
    output int     o_fail_count,
    output int     o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        mexp_pkg::t_word value;
        logic            bad;
    } t_power;

    t_power pending_powers[$];
    int     fail_total = 0;

    // base ^ exponent mod modulus, products kept at double width before reduction
    function automatic t_power power_mod(mexp_pkg::t_word b, mexp_pkg::t_word e,
                                         mexp_pkg::t_word m);
        t_power                            p;
        logic [2*mexp_pkg::WORD_BITS-1:0]  acc;
        logic [2*mexp_pkg::WORD_BITS-1:0]  sq;
        p.value = '0;
        p.bad   = 1'b0;
        if (e == '0) begin
            p.value = mexp_pkg::t_word'(1);
        end else if (m == '0) begin
            p.bad = 1'b1;
        end else begin
            acc = 1 % m;
            sq  = b % m;
            for (int k = 0; k < mexp_pkg::WORD_BITS; k++) begin
                if (e[k]) begin
                    acc = (acc * sq) % m;
                end
                sq = (sq * sq) % m;
            end
            p.value = acc[mexp_pkg::WORD_BITS-1:0];
        end
        return p;
    endfunction

    // queue a prediction per accepted word, check each returned word against the oldest
    always @(posedge i_clk) begin
        t_power exp_pow;
        if (i_rst_n) begin
            if (i_req.valid && i_req.ready) begin
                pending_powers.push_back(power_mod(i_req.base_value, i_req.exponent,
                                                   i_req.modulus));
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (pending_powers.size() == 0) begin
                    $display("%0t: unexpected word, power_result %h bad_modulus %b",
                             $time, i_rsp.power_result, i_rsp.bad_modulus);
                    fail_total++;
                end else begin
                    exp_pow = pending_powers.pop_front();
                    if (i_rsp.power_result !== exp_pow.value) begin
                        $display("%0t: power_result expected %h, actual %h",
                                 $time, exp_pow.value, i_rsp.power_result);
                        fail_total++;
                    end
                    if (i_rsp.bad_modulus !== exp_pow.bad) begin
                        $display("%0t: bad_modulus expected %b, actual %b",
                                 $time, exp_pow.bad, i_rsp.bad_modulus);
                        fail_total++;
                    end
                end
            end
        end
        o_fail_count  <= fail_total;
        o_outstanding <= pending_powers.size();
    end

endmodule

### tb/sv/tb_modular_exponentiation.sv
// Testbench top: drives base, exponent and modulus words with random idling and gives the verdict.
module tb_modular_exponentiation;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 280;
    localparam int RUN_LIMIT    = 3_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   outstanding;
    int   cycle_count = 0;
    int   rsp_hold = 0;
    logic calm = 1'b0;

    mexp_in_if  u_req_if ();
    mexp_out_if u_rsp_if ();

    modular_exponentiation u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (u_req_if),
        .o_rsp   (u_rsp_if)
    );

    mexp_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (u_req_if),
        .i_rsp         (u_rsp_if),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // idle span: mostly none or short, now and then long
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // stall the receiver at random, except in calm stretches
    always @(posedge i_clk) begin
        if (rsp_hold != 0) begin
            rsp_hold       <= rsp_hold - 1;
            u_rsp_if.ready <= 1'b0;
        end else begin
            u_rsp_if.ready <= 1'b1;
            if (!calm) begin
                rsp_hold <= idle_span();
            end
        end
    end

    // give up on a hang
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // offer one word after an optional gap and hold it until taken
    task automatic send_word(input mexp_pkg::t_word b, input mexp_pkg::t_word e,
                             input mexp_pkg::t_word m);
        int gap;
        gap = calm ? 0 : idle_span();
        if (gap != 0) begin
            u_req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        u_req_if.valid      <= 1'b1;
        u_req_if.base_value <= b;
        u_req_if.exponent   <= e;
        u_req_if.modulus    <= m;
        do @(posedge i_clk); while (!u_req_if.ready);
    endtask

    // drop valid and wait until every queued result has come back
    task automatic drain();
        u_req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    initial begin
        mexp_pkg::t_word b;
        mexp_pkg::t_word e;
        mexp_pkg::t_word m;
        int              r;

        u_req_if.valid      <= 1'b0;
        u_req_if.base_value <= '0;
        u_req_if.exponent   <= '0;
        u_req_if.modulus    <= '0;
        i_rst_n             <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero exponent, whatever the modulus
        send_word(32'd5, 32'd0, 32'd0);
        send_word(32'd7, 32'd0, 32'd1);
        send_word(32'hFFFF_FFFF, 32'd0, 32'd12345);
        send_word(32'd0, 32'd0, 32'd97);
        // zero modulus with a nonzero exponent
        send_word(32'd3, 32'd5, 32'd0);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        // modulus one
        send_word(32'd123, 32'd7, 32'd1);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
        // base at or above the modulus
        send_word(32'd1000, 32'd3, 32'd7);
        send_word(32'd13, 32'd13, 32'd13);
        send_word(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFE);
        // field extremes
        send_word(32'd0, 32'd9, 32'd97);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(32'd2, 32'd31, 32'hFFFF_FFFB);
        send_word(32'd2, 32'd1, 32'd3);
        send_word(32'd12345, 32'h8000_0000, 32'hFFFF_FFF1);
        send_word(32'd3, 32'd2, 32'd2);
        send_word(32'd7, 32'hFFFF_FFFF, 32'd2);
        send_word(32'd1, 32'hFFFF_FFFF, 32'd1000003);
        drain();

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            // switch between calm and idling stretches now and then
            if (n % 40 == 0) begin
                calm <= ($urandom_range(0, 2) == 0);
            end
            if (n == RANDOM_WORDS / 2) begin
                drain();
            end

            // modulus: mostly full width, some narrow, some tiny
            r = $urandom_range(0, 99);
            if (r < 60) begin
                m = $urandom;
            end else if (r < 85) begin
                m = $urandom_range(2, 32'hFFFF);
            end else begin
                m = $urandom_range(2, 255);
            end

            // exponent: mostly short to keep the run brisk, a quarter full width
            if ($urandom_range(0, 3) == 0) begin
                e = $urandom;
            end else begin
                e = $urandom & ((32'd1 << $urandom_range(1, 8)) - 1);
            end

            // base: random, or below the modulus
            b = $urandom;
            if ($urandom_range(0, 9) < 3 && m != '0) begin
                b = b % m;
            end

            // the special cases now and then
            r = $urandom_range(0, 99);
            if (r < 4) begin
                m = '0;
            end else if (r < 8) begin
                e = '0;
            end else if (r < 11) begin
                m = mexp_pkg::t_word'(1);
            end

            send_word(b, e, m);
        end
        u_req_if.valid <= 1'b0;

        // wait for the last results, then a little longer for strays
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        if (fail_count == 0 && outstanding == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### modular_exponentiation.f
src/mexp_pkg.sv
src/mexp_if.sv
src/mexp_mulmod.sv
src/modular_exponentiation.sv
tb/sv/mexp_checker.sv
tb/sv/tb_modular_exponentiation.sv
